@@ design/psvm_pkg.sv @@
// Package with types, constants and register indexes of the voice mixer.
package psvm_pkg;

    localparam int VOICES_DEF = 84;
    localparam int FRAMES_DEF = 65536;
    localparam int SAMPLE_W_DEF = 16;

    localparam logic [15:0] GAIN_RST = 16'd6554;
    localparam logic [15:0] FDIV_RST = 16'd3000;
    localparam logic [15:0] FLIM_RST = 16'd44100;
    localparam logic [6:0]  LOW_RST = 7'd9;

    localparam logic [2:0] OP_PRESS = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_TICK = 3'd2;
    localparam logic [2:0] OP_LOAD = 3'd3;
    localparam logic [2:0] OP_LENGTH = 3'd4;

    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_FDIV = 2'd1;
    localparam logic [1:0] REG_FLIM = 2'd2;
    localparam logic [1:0] REG_LOW = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         note;
        logic [15:0]        frame_address;
        logic [16:0]        voice_length;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_VOICE,
        ST_DIVL,
        ST_DIVR,
        ST_NEXT,
        ST_SCALE,
        ST_SAT
    } t_state;

endpackage

@@ design/psvm_div.sv @@
// Serial restoring divider for the fade attenuation, one quotient bit a cycle.
module psvm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic [16:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    logic [31:0] r_mag;
    logic [16:0] r_rem;
    logic [16:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    logic [17:0] w_sub;

    assign w_sh = {r_rem, r_mag[31]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The partial remainder always stays below the divisor, so 17 bits hold it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[31];
            r_mag <= i_num[31] ? 32'(-i_num) : 32'(i_num);
            r_rem <= 17'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_sub[17]) begin
                r_rem <= w_sub[16:0];
                r_mag <= {r_mag[30:0], 1'b1};
            end else begin
                r_rem <= w_sh[16:0];
                r_mag <= {r_mag[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd31);
    // Final quotient bit is formed combinationally in the done cycle.
    logic [31:0] w_q;
    assign w_q = {r_mag[30:0], ~w_sub[17]};
    assign o_quot = r_neg ? -$signed(w_q) : $signed(w_q);
endmodule

@@ design/polyphonic_sample_voice_mixer.sv @@
// Top level of the polyphonic sample voice mixer.
// One item at a time; press, release, load, length and unused ops end in the decode state.
// A tick goes on to visit each voice in turn (fetch, store read, next), then scales and saturates; each
// fading voice with a frame left has both channels divided in turn on the shared serial divider.
// A tick's frame is strobed as busy falls; the receiver cannot stall.
// Reset: synchronous, active low; registers take defaults, voices stop, lengths read as zero.
module polyphonic_sample_voice_mixer #(
    parameter int VOICES = psvm_pkg::VOICES_DEF,
    parameter int FRAMES_PER_VOICE = psvm_pkg::FRAMES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  psvm_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output psvm_pkg::t_out_item o_item
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int FW = $clog2(FRAMES_PER_VOICE);
    localparam int LW = FW + 1;
    localparam int AW = VW + FW;
    localparam int DEPTH = VOICES * FRAMES_PER_VOICE;

    // Configuration registers.
    logic [15:0] r_gain, r_fdiv, r_flim;
    logic [6:0]  r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= psvm_pkg::GAIN_RST;
            r_fdiv <= psvm_pkg::FDIV_RST;
            r_flim <= psvm_pkg::FLIM_RST;
            r_low <= psvm_pkg::LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psvm_pkg::REG_GAIN: r_gain <= i_cfg_data;
                psvm_pkg::REG_FDIV: r_fdiv <= i_cfg_data;
                psvm_pkg::REG_FLIM: r_flim <= i_cfg_data;
                psvm_pkg::REG_LOW: r_low <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Per-voice state; flags in flip-flops, counters in small arrays read at one address.
    // Position and fade count are always set by a press or a release before they are used.
    // A length reads as zero until its voice has been given one.
    logic [VOICES-1:0] r_held, r_fading, r_len_ok;
    logic [LW-1:0]     r_pos [VOICES];
    logic [15:0]       r_fcnt [VOICES];
    logic [LW-1:0]     r_len [VOICES];
    logic [31:0]       r_store [DEPTH];

    // Captured item and voice decode.
    psvm_pkg::t_in_item r_it;
    logic [7:0]         w_diff;
    logic               w_inrange;
    logic [VW-1:0]      w_iv;

    assign w_diff = {1'b0, r_it.note} - {1'b0, r_low};
    assign w_inrange = (r_it.note >= r_low) && ({24'd0, w_diff} < 32'(VOICES));
    assign w_iv = w_diff[VW-1:0];

    psvm_pkg::t_state r_state, n_state;
    logic [VW-1:0]    r_v;
    logic [VW-1:0]    w_nv;
    logic signed [39:0] r_suml, r_sumr;
    logic [LW-1:0]    r_cpos, r_clen;
    logic [15:0]      r_ccnt;
    logic [31:0]      r_rd;
    logic signed [55:0] r_pl, r_pr;
    logic             r_valid;
    psvm_pkg::t_out_item r_out;
    // Flags that the registered store read issued in ST_WAIT has arrived, in ST_VOICE.
    logic             r_rd_ok;

    logic [AW-1:0] w_addr;
    logic          w_avail;
    logic [16:0]   w_cnt1;
    logic          div_start, div_done;
    logic signed [31:0] div_num, div_q;

    assign w_avail = r_cpos < r_clen;
    assign w_cnt1 = {1'b0, r_ccnt} + 17'd1;
    // Voice whose state is fetched when the sequencer enters ST_WAIT.
    assign w_nv = (r_state == psvm_pkg::ST_NEXT) ? r_v + VW'(1) : r_v;

    always_comb begin
        if (r_state == psvm_pkg::ST_IDLE || r_state == psvm_pkg::ST_RD) begin
            w_addr = AW'(w_iv) * AW'(FRAMES_PER_VOICE) + AW'(r_it.frame_address);
        end else begin
            w_addr = AW'(r_v) * AW'(FRAMES_PER_VOICE) + (w_avail ? AW'(r_cpos) : AW'(0));
        end
    end

    psvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({1'b0, r_fdiv} + w_cnt1),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // The right channel divide is started from ST_DIVL, the left one from ST_VOICE.
    logic signed [31:0] w_sl, w_sr;
    assign w_sl = 32'($signed(r_rd[31:16]));
    assign w_sr = 32'($signed(r_rd[15:0]));
    assign div_num = (r_state == psvm_pkg::ST_DIVL ? w_sr : w_sl) * $signed({16'd0, r_fdiv});

    always_comb begin
        n_state = r_state;
        div_start = 1'b0;
        case (r_state)
            psvm_pkg::ST_IDLE: if (start) n_state = psvm_pkg::ST_RD;
            psvm_pkg::ST_RD: begin
                if (r_it.op == psvm_pkg::OP_TICK) n_state = psvm_pkg::ST_WAIT;
                else n_state = psvm_pkg::ST_IDLE;
            end
            psvm_pkg::ST_WAIT: n_state = psvm_pkg::ST_VOICE;
            psvm_pkg::ST_VOICE: begin
                if (!r_held[r_v] && r_fading[r_v] && w_avail && r_rd_ok) begin
                    n_state = psvm_pkg::ST_DIVL;
                    div_start = 1'b1;
                end else if (r_rd_ok) begin
                    n_state = psvm_pkg::ST_NEXT;
                end
            end
            psvm_pkg::ST_DIVL: if (div_done) begin
                n_state = psvm_pkg::ST_DIVR;
                div_start = 1'b1;
            end
            psvm_pkg::ST_DIVR: if (div_done) n_state = psvm_pkg::ST_NEXT;
            psvm_pkg::ST_NEXT: begin
                if (32'(r_v) == 32'(VOICES - 1)) n_state = psvm_pkg::ST_SCALE;
                else n_state = psvm_pkg::ST_WAIT;
            end
            psvm_pkg::ST_SCALE: n_state = psvm_pkg::ST_SAT;
            psvm_pkg::ST_SAT: n_state = psvm_pkg::ST_IDLE;
            default: n_state = psvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= psvm_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psvm_pkg::ST_RD && r_it.op == psvm_pkg::OP_LOAD && w_inrange
            && 32'(r_it.frame_address) < 32'(FRAMES_PER_VOICE)) begin
            r_store[w_addr] <= {r_it.left_sample, r_it.right_sample};
        end
        r_rd <= r_store[w_addr];
    end

    function automatic logic signed [15:0] sat(input logic signed [55:0] x);
        logic signed [55:0] q;
        q = x / 56'sd65536;
        if (q > 56'sd32767) sat = 16'sh7fff;
        else if (q < -56'sd32768) sat = 16'sh8000;
        else sat = q[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fading <= '0;
            r_len_ok <= '0;
            r_valid <= 1'b0;
            r_rd_ok <= 1'b0;
            r_v <= '0;
        end else begin
            r_valid <= (r_state == psvm_pkg::ST_SAT);
            r_rd_ok <= (r_state == psvm_pkg::ST_WAIT);
            case (r_state)
                psvm_pkg::ST_IDLE: begin
                    if (start) r_it <= i_item;
                    r_v <= '0;
                    r_suml <= '0;
                    r_sumr <= '0;
                end
                psvm_pkg::ST_RD: begin
                    if (w_inrange) begin
                        case (r_it.op)
                            psvm_pkg::OP_PRESS: begin
                                r_pos[w_iv] <= '0;
                                r_held[w_iv] <= 1'b1;
                            end
                            psvm_pkg::OP_RELEASE: if (r_held[w_iv]) begin
                                r_fcnt[w_iv] <= '0;
                                r_fading[w_iv] <= 1'b1;
                                r_held[w_iv] <= 1'b0;
                            end
                            psvm_pkg::OP_LENGTH: begin
                                r_len_ok[w_iv] <= 1'b1;
                                if (32'(r_it.voice_length) > 32'(FRAMES_PER_VOICE))
                                    r_len[w_iv] <= LW'(FRAMES_PER_VOICE);
                                else r_len[w_iv] <= LW'(r_it.voice_length);
                            end
                            default: ;
                        endcase
                    end
                end
                psvm_pkg::ST_VOICE: if (r_rd_ok) begin
                    if (r_held[r_v]) begin
                        if (w_avail) begin
                            r_suml <= r_suml + 40'(w_sl);
                            r_sumr <= r_sumr + 40'(w_sr);
                            r_pos[r_v] <= r_cpos + LW'(1);
                        end else r_held[r_v] <= 1'b0;
                    end else if (r_fading[r_v] && !w_avail) begin
                        r_fading[r_v] <= 1'b0;
                    end
                end
                psvm_pkg::ST_DIVL: if (div_done) r_suml <= r_suml + 40'(div_q);
                psvm_pkg::ST_DIVR: if (div_done) begin
                    r_sumr <= r_sumr + 40'(div_q);
                    if (w_cnt1 > {1'b0, r_flim}) r_fading[r_v] <= 1'b0;
                    else begin
                        r_fcnt[r_v] <= w_cnt1[15:0];
                        r_pos[r_v] <= r_cpos + LW'(1);
                    end
                end
                psvm_pkg::ST_NEXT: begin
                    r_v <= r_v + VW'(1);
                end
                psvm_pkg::ST_SCALE: begin
                    r_pl <= 56'(r_suml) * $signed({40'd0, r_gain});
                    r_pr <= 56'(r_sumr) * $signed({40'd0, r_gain});
                end
                psvm_pkg::ST_SAT: begin
                    r_out.left_out <= sat(r_pl);
                    r_out.right_out <= sat(r_pr);
                end
                default: ;
            endcase
            if (n_state == psvm_pkg::ST_WAIT) begin
                r_cpos <= r_pos[w_nv];
                r_clen <= r_len_ok[w_nv] ? r_len[w_nv] : '0;
                r_ccnt <= r_fcnt[w_nv];
            end
        end
    end

    assign busy = (r_state != psvm_pkg::ST_IDLE);
    assign o_valid = r_valid;
    assign o_item = r_out;
endmodule

@@ design/psvm_check.sv @@
// Port-level checker for the voice mixer, bound to the top level.
module psvm_check (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after start");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result beat longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid) else $error("not idle after reset");
endmodule

bind polyphonic_sample_voice_mixer psvm_check u_psvm_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

@@ tb/polyphonic_sample_voice_mixer_tb.sv @@
// Self-checking testbench for the polyphonic sample voice mixer.
`timescale 1ns / 100ps

module polyphonic_sample_voice_mixer_tb;
    import psvm_pkg::*;

    localparam int NV = VOICES_DEF;
    localparam int NF = FRAMES_DEF;
    localparam int IW = $bits(t_in_item);
    localparam longint CYCLE_LIMIT = 6000000;
    // Long enough for a tick with every voice fading to finish, with margin.
    localparam int SETTLE = 7000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    t_out_item   o_item;

    polyphonic_sample_voice_mixer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    always #5 i_clk = ~i_clk;

    // Items waiting for the driver, and mixed frames waiting for the monitor.
    t_in_item  beat_q[$];
    t_out_item frame_q[$];
    int        err_cnt = 0;
    int        idle_pct = 0;
    longint    cycle_cnt = 0;

    // Shadow of the mixer: registers, per-voice play state and the sample store.
    logic [15:0] gain_r, fdiv_r, flim_r;
    logic [6:0]  low_r;
    bit          held[NV];
    bit          fading[NV];
    int          pos[NV];
    int          fcnt[NV];
    int          vlen[NV];
    logic signed [15:0] store_l[int];
    logic signed [15:0] store_r[int];
    // Number of frames loaded without a hole from frame zero, per voice.
    int          loaded_run[NV];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic longint scale_sat(input longint sum);
        longint x;
        x = (sum * longint'(gain_r)) / 65536;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x;
    endfunction

    // Advances the shadow by one item and queues the frame a tick produces.
    task automatic mix_step(input t_in_item it);
        int v, key, p, c;
        bit ok, avail;
        longint sl, sr, den;
        t_out_item fr;
        v = int'(it.note) - int'(low_r);
        ok = (v >= 0) && (v < NV);
        case (it.op)
            OP_PRESS: if (ok) begin
                pos[v] = 0;
                held[v] = 1'b1;
            end
            OP_RELEASE: if (ok && held[v]) begin
                fcnt[v] = 0;
                fading[v] = 1'b1;
                held[v] = 1'b0;
            end
            OP_LOAD: if (ok) begin
                key = v * NF + int'(it.frame_address);
                store_l[key] = it.left_sample;
                store_r[key] = it.right_sample;
                while (loaded_run[v] < NF && store_l.exists(v * NF + loaded_run[v]))
                    loaded_run[v]++;
            end
            OP_LENGTH: if (ok) begin
                vlen[v] = (int'(it.voice_length) > NF) ? NF : int'(it.voice_length);
            end
            OP_TICK: begin
                sl = 0;
                sr = 0;
                for (int k = 0; k < NV; k++) begin
                    p = pos[k];
                    avail = p < vlen[k];
                    key = k * NF + (avail ? p : 0);
                    if (held[k]) begin
                        if (avail) begin
                            sl += store_l[key];
                            sr += store_r[key];
                            pos[k] = p + 1;
                        end else begin
                            held[k] = 1'b0;
                        end
                    end else if (fading[k]) begin
                        c = fcnt[k];
                        if (avail) begin
                            c++;
                            den = longint'(fdiv_r) + c;
                            sl += (longint'(store_l[key]) * longint'(fdiv_r)) / den;
                            sr += (longint'(store_r[key]) * longint'(fdiv_r)) / den;
                        end
                        if (!avail || c > int'(flim_r)) begin
                            fading[k] = 1'b0;
                        end else begin
                            fcnt[k] = c & 16'hFFFF;
                            pos[k] = p + 1;
                        end
                    end
                end
                fr.left_out = 16'(scale_sat(sl));
                fr.right_out = 16'(scale_sat(sr));
                frame_q.push_back(fr);
            end
            default: ;
        endcase
    endtask

    // Builds an item with random filler in the fields its op does not use, steps the shadow, queues it.
    task automatic send(input logic [2:0] op, input int note, input int addr, input int len,
                        input int lv, input int rv);
        t_in_item it;
        it = IW'({$urandom, $urandom, $urandom});
        it.op = op;
        it.note = 7'(note);
        if (op == OP_LOAD) begin
            it.frame_address = 16'(addr);
            it.left_sample = 16'(lv);
            it.right_sample = 16'(rv);
        end
        if (op == OP_LENGTH) it.voice_length = 17'(len);
        mix_step(it);
        beat_q.push_back(it);
    endtask

    // Blocks until the mixer has drained everything and sits idle.
    task automatic drain();
        while (beat_q.size() != 0 || start || frame_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_GAIN: gain_r = 16'(val);
            REG_FDIV: fdiv_r = 16'(val);
            REG_FLIM: flim_r = 16'(val);
            REG_LOW:  low_r = 7'(val);
            default: ;
        endcase
    endtask

    function automatic int rand_sample();
        case ($urandom_range(3))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Random traffic over a handful of voices, mostly well-formed note activity.
    task automatic random_items(input int count);
        int maxv, v, r, note;
        maxv = 127 - int'(low_r);
        if (maxv > NV - 1) maxv = NV - 1;
        for (int n = 0; n < count; n++) begin
            v = ($urandom_range(7) == 0) ? maxv : $urandom_range((maxv < 5) ? maxv : 5);
            note = int'(low_r) + v;
            r = $urandom_range(99);
            if (r < 30) begin
                // Grow the loaded run, with an occasional write at a random address.
                if ($urandom_range(4) == 0)
                    send(OP_LOAD, note, $urandom_range(65535), 0, rand_sample(), rand_sample());
                else if (loaded_run[v] < NF)
                    send(OP_LOAD, note, loaded_run[v], 0, rand_sample(), rand_sample());
            end else if (r < 40) begin
                if (!held[v] && !fading[v] && $urandom_range(3) == 0) begin
                    // An oversized length saturates; it is cut back before anything plays.
                    send(OP_LENGTH, note, 0, $urandom_range(131071, NF), 0, 0);
                    send(OP_LENGTH, note, 0, loaded_run[v], 0, 0);
                end else begin
                    send(OP_LENGTH, note, 0, $urandom_range(loaded_run[v]), 0, 0);
                end
            end else if (r < 55) begin
                send(OP_PRESS, note, 0, 0, 0, 0);
            end else if (r < 66) begin
                send(OP_RELEASE, note, 0, 0, 0, 0);
            end else if (r < 96) begin
                send(OP_TICK, note, 0, 0, 0, 0);
            end else if (r < 98) begin
                send(3'($urandom_range(7, 5)), note, 0, 0, 0, 0);
            end else if (low_r != 0) begin
                send(3'($urandom_range(1)), $urandom_range(int'(low_r) - 1), 0, 0, 0, 0);
            end else begin
                send(OP_LOAD, NV, 0, 0, rand_sample(), rand_sample());
            end
        end
    endtask

    // Driver: keeps start high until the beat is taken, then idles at random.
    always @(posedge i_clk) begin
        logic start_n;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            start_n = start && busy;
            if (!start_n && beat_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_item <= beat_q.pop_front();
                start_n = 1'b1;
            end
            start <= start_n;
        end
    end

    // Monitor: every strobed frame is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (frame_q.size() == 0) begin
                report("unexpected frame", o_item.left_out, 0);
            end else begin
                want = frame_q.pop_front();
                if (o_item.left_out !== want.left_out)
                    report("left_out", o_item.left_out, want.left_out);
                if (o_item.right_out !== want.right_out)
                    report("right_out", o_item.right_out, want.right_out);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        gain_r = GAIN_RST;
        fdiv_r = FDIV_RST;
        flim_r = FLIM_RST;
        low_r = LOW_RST;
        for (int k = 0; k < NV; k++) begin
            held[k] = 0; fading[k] = 0; pos[k] = 0; fcnt[k] = 0; vlen[k] = 0;
            loaded_run[k] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings; voice zero is note nine.
        idle_pct = 38;
        send(OP_LOAD, 9, 0, 0, 32767, -32768);
        send(OP_LOAD, 9, 1, 0, -32768, 32767);
        send(OP_LOAD, 9, 2, 0, 0, -1);
        send(OP_LOAD, 10, 0, 0, 12345, -12345);
        send(OP_LOAD, 11, 65535, 0, -1, 1);
        send(OP_LENGTH, 9, 0, 3, 0, 0);
        send(OP_LENGTH, 10, 0, 1, 0, 0);
        send(OP_LENGTH, 11, 0, 131071, 0, 0);
        send(OP_LENGTH, 11, 0, 0, 0, 0);
        send(OP_PRESS, 0, 0, 0, 0, 0);       // Below the lowest note.
        send(OP_PRESS, 93, 0, 0, 0, 0);      // One past the highest voice.
        send(3'd5, 9, 0, 0, 0, 0);
        send(3'd6, 9, 0, 0, 0, 0);
        send(3'd7, 9, 0, 0, 0, 0);
        send(OP_RELEASE, 10, 0, 0, 0, 0);    // Release of a voice that is not held.
        send(OP_PRESS, 9, 0, 0, 0, 0);
        send(OP_PRESS, 10, 0, 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0);
        send(OP_RELEASE, 9, 0, 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0);
        send(OP_PRESS, 9, 0, 0, 0, 0);       // Press while the voice is still fading.
        send(OP_TICK, 0, 0, 0, 0, 0);
        send(OP_LENGTH, 9, 0, 0, 0, 0);      // Length cut below the play position.
        send(OP_TICK, 0, 0, 0, 0, 0);
        send(OP_TICK, 0, 0, 0, 0, 0);
        drain();

        // Extremes: full gain, zero divisor, zero limit, a single reachable voice.
        cfg_write(REG_GAIN, 65535);
        cfg_write(REG_FDIV, 0);
        cfg_write(REG_FLIM, 0);
        cfg_write(REG_LOW, 127);
        random_items(30);
        drain();

        idle_pct = 79;
        cfg_write(REG_GAIN, 20000);
        cfg_write(REG_FDIV, 5);
        cfg_write(REG_FLIM, 40);
        cfg_write(REG_LOW, 44);
        random_items(120);
        drain();

        idle_pct = 0;
        cfg_write(REG_GAIN, $urandom_range(65535));
        cfg_write(REG_FDIV, $urandom_range(100, 1));
        cfg_write(REG_FLIM, $urandom_range(200));
        cfg_write(REG_LOW, 0);
        random_items(115);
        drain();

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
